// File: rtl/core/mme_pkg.sv
package mme_pkg;

  // Store geometry follows from the 6-bit element index.
  localparam int ADDR_W      = 6;
  localparam int STORE_DEPTH = 64;
  // Row/column indexes and dimension registers.
  localparam int IDX_W       = 3;
  localparam int DIM_W       = 4;
  // Field widths of the channels.
  localparam int ELEM_W      = 16;
  localparam int SUM_W       = 35;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_START  = 2'd2
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] inner_dim;
    logic [DIM_W-1:0] cols_b;
  } dims_t;

  // One issued product step, travelling with the store reads.
  typedef struct packed {
    logic             issue;
    logic             first;
    logic             last;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mac_ctl_t;

  typedef struct packed {
    logic done;
    logic slot_free;
  } mac_stat_t;

endpackage

// File: rtl/core/mme_in_if.sv
interface mme_in_if;
  import mme_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [ADDR_W-1:0]        element_index;
  logic signed [ELEM_W-1:0] element_value;

  modport source (output valid, output action, output element_index,
                  output element_value, input ready);
  modport sink   (input valid, input action, input element_index,
                  input element_value, output ready);
endinterface

// File: rtl/core/mme_out_if.sv
interface mme_out_if;
  import mme_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] product_value;
  logic [IDX_W-1:0]        result_row;
  logic [IDX_W-1:0]        result_col;
  logic                    last_result;

  modport source (output valid, output product_value, output result_row,
                  output result_col, output last_result, input ready);
  modport sink   (input valid, input product_value, input result_row,
                  input result_col, input last_result, output ready);
endinterface

// File: rtl/core/mme_cfg_if.sv
interface mme_cfg_if;
  import mme_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/mme_ram.sv
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/mme_seq.sv
module mme_seq #(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  mme_in_if.sink                  in_ch,
  input  mme_pkg::dims_t          dims,
  input  mme_pkg::mac_stat_t      stat,
  output mme_pkg::mac_ctl_t       ctl,
  output logic                    a_we,
  output logic                    b_we,
  output logic [mme_pkg::ADDR_W-1:0] wr_addr,
  output logic [DATA_WIDTH-1:0]   wr_data,
  output logic [mme_pkg::ADDR_W-1:0] a_raddr,
  output logic [mme_pkg::ADDR_W-1:0] b_raddr
);
  import mme_pkg::*;

  localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIM);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SLOT  = 4'b0010,
    ST_ISSUE = 4'b0100,
    ST_DRAIN = 4'b1000
  } seq_state_t;

  seq_state_t       state_r, state_nxt;
  logic [DIM_W-1:0] m_r, m_nxt, n_r, n_nxt, p_r, p_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic [ADDR_W-1:0] a_addr_r, a_addr_nxt, b_addr_r, b_addr_nxt;
  logic [DIM_W-1:0] m_cl, n_cl, p_cl;
  logic             accept, k_last, j_last, i_last;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > MAX_DIM_C) begin
      r = MAX_DIM_C;
    end else begin
      r = d;
    end
    return r;
  endfunction

  assign m_cl = clamp_dim(dims.rows_a);
  assign n_cl = clamp_dim(dims.inner_dim);
  assign p_cl = clamp_dim(dims.cols_b);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign a_we    = accept && (in_ch.action == ACT_LOAD_A);
  assign b_we    = accept && (in_ch.action == ACT_LOAD_B);
  assign wr_addr = in_ch.element_index;
  assign wr_data = DATA_WIDTH'(in_ch.element_value);
  assign a_raddr = a_addr_r;
  assign b_raddr = b_addr_r;

  assign k_last = (DIM_W'(k_r) + DIM_W'(1)) == n_r;
  assign j_last = (DIM_W'(j_r) + DIM_W'(1)) == p_r;
  assign i_last = (DIM_W'(i_r) + DIM_W'(1)) == m_r;

  always_comb begin
    ctl.issue     = (state_r == ST_ISSUE);
    ctl.first     = (k_r == '0);
    ctl.last      = k_last;
    ctl.last_elem = i_last && j_last;
    ctl.row       = i_r;
    ctl.col       = j_r;
  end

  always_comb begin
    state_nxt    = state_r;
    m_nxt        = m_r;
    n_nxt        = n_r;
    p_nxt        = p_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    row_base_nxt = row_base_r;
    a_addr_nxt   = a_addr_r;
    b_addr_nxt   = b_addr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_ch.action == ACT_START)) begin
          m_nxt        = m_cl;
          n_nxt        = n_cl;
          p_nxt        = p_cl;
          i_nxt        = '0;
          j_nxt        = '0;
          row_base_nxt = '0;
          state_nxt    = ST_SLOT;
        end
      end
      ST_SLOT: begin
        if (stat.slot_free) begin
          k_nxt      = '0;
          a_addr_nxt = row_base_r;
          b_addr_nxt = ADDR_W'(j_r);
          state_nxt  = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        k_nxt      = k_r + IDX_W'(1);
        a_addr_nxt = a_addr_r + ADDR_W'(1);
        b_addr_nxt = b_addr_r + ADDR_W'(p_r);
        if (k_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.done) begin
          if (i_last && j_last) begin
            state_nxt = ST_IDLE;
          end else if (j_last) begin
            j_nxt        = '0;
            i_nxt        = i_r + IDX_W'(1);
            row_base_nxt = row_base_r + ADDR_W'(n_r);
            state_nxt    = ST_SLOT;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = ST_SLOT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      m_r     <= DIM_W'(1);
      n_r     <= DIM_W'(1);
      p_r     <= DIM_W'(1);
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      m_r     <= m_nxt;
      n_r     <= n_nxt;
      p_r     <= p_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_base_r <= row_base_nxt;
    a_addr_r   <= a_addr_nxt;
    b_addr_r   <= b_addr_nxt;
  end

  // A finished sum only arrives while the sequencer waits for it.
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (state_r == ST_DRAIN))
    else $error("mme_seq: sum finished outside the drain state");

  // Latched dimensions always lie in the legal range.
  a_dims_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (m_r != '0) && (n_r != '0) && (p_r != '0) &&
    (m_r <= MAX_DIM_C) && (n_r <= MAX_DIM_C) && (p_r <= MAX_DIM_C))
    else $error("mme_seq: latched dimension out of range");

  // The inner walk never runs past the inner dimension.
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE) |-> (DIM_W'(k_r) < n_r))
    else $error("mme_seq: inner index beyond inner dimension");

endmodule

// File: rtl/core/mme_mac.sv
module mme_mac #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mme_pkg::mac_ctl_t     ctl,
  input  logic [DATA_WIDTH-1:0] a_rdata,
  input  logic [DATA_WIDTH-1:0] b_rdata,
  output mme_pkg::mac_stat_t    stat,
  mme_out_if.source             out_ch
);
  import mme_pkg::*;

  localparam int PROD_W = 2 * DATA_WIDTH;

  mac_ctl_t                 ctl1_r, ctl2_r;
  logic signed [PROD_W-1:0] product_r;
  logic signed [SUM_W-1:0]  prod_ext;
  logic signed [SUM_W-1:0]  acc_r, sum_nxt;
  logic                     out_valid_r, load;
  logic signed [SUM_W-1:0]  out_value_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic                     out_last_r;

  // Sign-extend the product, then keep the sum modulo 2^SUM_W.
  assign prod_ext = SUM_W'(product_r);
  assign sum_nxt  = (ctl2_r.first ? '0 : acc_r) + prod_ext;
  assign load     = ctl2_r.issue && ctl2_r.last;

  assign stat.done      = load;
  assign stat.slot_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r      <= '0;
      ctl2_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl1_r.issue) begin
      product_r <= $signed(a_rdata) * $signed(b_rdata);
    end
    if (ctl2_r.issue) begin
      acc_r <= sum_nxt;
    end
    if (load) begin
      out_value_r <= sum_nxt;
      out_row_r   <= ctl2_r.row;
      out_col_r   <= ctl2_r.col;
      out_last_r  <= ctl2_r.last_elem;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.product_value = out_value_r;
  assign out_ch.result_row    = out_row_r;
  assign out_ch.result_col    = out_col_r;
  assign out_ch.last_result   = out_last_r;

  // A finished sum must never land on a result still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ch.ready))
    else $error("mme_mac: result register overwritten");

  // Products of one sum arrive back to back, with no gap.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl2_r.issue && !ctl2_r.first) |-> $past(ctl2_r.issue && !ctl2_r.last))
    else $error("mme_mac: gap inside one accumulation");

  // A sum that starts must follow a completed one or an idle pipeline.
  a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl2_r.issue && ctl2_r.first) |-> !$past(ctl2_r.issue && !ctl2_r.last))
    else $error("mme_mac: new sum started before previous one ended");

endmodule

// File: rtl/core/matrix_multiply_engine_unit.sv
// Channel  Dir  Payload                                          Accepted when
// in_ch    in   action, element_index, element_value             valid && ready
// out_ch   out  product_value, result_row, result_col, last_result valid && ready
// cfg_ch   in   index (0 rows_a, 1 inner_dim, 2 cols_b), data    valid && ready
//
// A load item is written to its store as it is taken; an action code of 3 is
// consumed and does nothing. After a start item is taken the input stays not
// ready until the sum of the last result element completes: each result element
// first claims the result register, then issues its inner_dim products through
// the one shared multiply-accumulate unit, fed by one read port on each element
// store, and then drains the read and multiply stages. Each result is offered in
// the cycle after its sum completes. Reset (rst_n low, synchronous) sets every
// dimension to 1 and empties the pipeline; the element stores are not cleared.
// The configuration port is always ready. A stalled result holds the next
// element's products back.
module matrix_multiply_engine_unit #(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  mme_in_if.sink    in_ch,
  mme_out_if.source out_ch,
  mme_cfg_if.sink   cfg_ch
);
  import mme_pkg::*;

  // Raw dimension registers; the sequencer clamps them when a start is taken.
  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  dims_t            dims;

  mac_ctl_t  ctl;
  mac_stat_t stat;

  logic                  a_we, b_we;
  logic [ADDR_W-1:0]     wr_addr, a_raddr, b_raddr;
  logic [DATA_WIDTH-1:0] wr_data, a_rdata, b_rdata;

  assign cfg_ch.ready = 1'b1;

  // Writes to indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(1);
      inner_dim_r <= DIM_W'(1);
      cols_b_r    <= DIM_W'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_ROWS_A:    rows_a_r    <= cfg_ch.data;
        CFG_INNER_DIM: inner_dim_r <= cfg_ch.data;
        CFG_COLS_B:    cols_b_r    <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    dims.rows_a    = rows_a_r;
    dims.inner_dim = inner_dim_r;
    dims.cols_b    = cols_b_r;
  end

  // The sequencer takes load and start items, writes the stores, and walks
  // the result elements in row-major order.
  mme_seq #(
    .MAX_DIM   (MAX_DIM),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .dims   (dims),
    .stat   (stat),
    .ctl    (ctl),
    .a_we   (a_we),
    .b_we   (b_we),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .a_raddr(a_raddr),
    .b_raddr(b_raddr)
  );

  // Element stores for A and B, row-major, registered read.
  mme_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(STORE_DEPTH)
  ) u_store_a (
    .clk  (clk),
    .we   (a_we),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(a_raddr),
    .rdata(a_rdata)
  );

  mme_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(STORE_DEPTH)
  ) u_store_b (
    .clk  (clk),
    .we   (b_we),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  // Shared multiply-accumulate unit with the result register.
  mme_mac #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .a_rdata(a_rdata),
    .b_rdata(b_rdata),
    .stat   (stat),
    .out_ch (out_ch)
  );

endmodule
